@@ rtl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants, types and helpers of the point set centroid shift core.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Point buffer capacity and the widths that follow from it
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SUM_W      = COORD_W + IDX_W;
  localparam int unsigned WIDE_W     = COORD_W + 2;
  localparam int unsigned PT_W       = 3 * COORD_W;
  localparam int unsigned DIV_STEP_W = $clog2(SUM_W);

  // Register file geometry
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned ADDR_W   = $clog2(4 * NUM_REGS);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SHIFT_X = 2'd1,
    REG_SHIFT_Y = 2'd2,
    REG_SHIFT_Z = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic               centering_mode;
    logic [COORD_W-1:0] shift_x;
    logic [COORD_W-1:0] shift_y;
    logic [COORD_W-1:0] shift_z;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_PREP,
    ST_EMIT,
    ST_DRAIN
  } state_e;

  // Sign-extend a coordinate to the wide working width
  function automatic logic [WIDE_W-1:0] ext_wide(input logic [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Clamp a wide signed value to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] top;
    top = v[WIDE_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/psc_ram.sv @@
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/psc_div.sv @@
// ----------------------------------------------------------------------------
// psc_div
// Bit-serial signed divider: axis sum over point count, truncating toward
// zero. One quotient bit per cycle, one for each of the SUM_W dividend bits.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [psc_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [psc_pkg::SUM_W-1:0]  quotient_o
);
  import psc_pkg::*;

  localparam logic [DIV_STEP_W-1:0] LastStep = DIV_STEP_W'(SUM_W - 1);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  neg_q, neg_d;
  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      dvs_q, dvs_d;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    run_d  = run_q;
    done_d = done_q;
    step_d = step_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      // Load the magnitude of the dividend and remember its sign
      run_d  = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? (SUM_W'(0) - dividend_i) : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      quo_d  = {quo_q[SUM_W-2:0], fits};
      rem_d  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // Restore the sign of the quotient
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (SUM_W'(0) - quo_q) : quo_q;

endmodule

@@ rtl/psc_regs.sv @@
// ----------------------------------------------------------------------------
// psc_regs
// APB-style register file: centering mode and the three shift registers.
// ----------------------------------------------------------------------------
module psc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]  paddr,
  input  logic [psc_pkg::DATA_W-1:0]  pwdata,
  output logic [psc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output psc_pkg::cfg_t               cfg_o
);
  import psc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:    cfg_d.centering_mode = pwdata[0];
        REG_SHIFT_X: cfg_d.shift_x        = pwdata[COORD_W-1:0];
        REG_SHIFT_Y: cfg_d.shift_y        = pwdata[COORD_W-1:0];
        REG_SHIFT_Z: cfg_d.shift_z        = pwdata[COORD_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centering_mode <= 1'b1;
      cfg_q.shift_x        <= '0;
      cfg_q.shift_y        <= '0;
      cfg_q.shift_z        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_MODE:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.centering_mode};
      REG_SHIFT_X: prdata = cfg_q.shift_x;
      REG_SHIFT_Y: prdata = cfg_q.shift_y;
      REG_SHIFT_Z: prdata = cfg_q.shift_z;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/point_set_centroid_shift_core.sv @@
// ----------------------------------------------------------------------------
// point_set_centroid_shift_core
// 3D point set centering: buffers a set, divides the axis sums by the point
// count and replays each point minus the centroid plus the shift, saturated.
// ----------------------------------------------------------------------------
// Usage: a point is taken on start while busy is low. In additive mode every
// point is taken back to back, one per cycle, and its shifted result shows on
// valid_o in the following cycle. In centering mode points load one per cycle
// into the point RAM; the point carrying set_end raises busy while the core
// runs a launch state, the 38-step bit-serial divider and its hand-off, an
// offset state, one RAM read per held point and a drain state. The n held
// points leave on consecutive cycles, one per RAM read, the last one flagged
// run_last_o in the cycle busy falls. valid_o is a one-cycle strobe with no
// back-pressure: capture every beat as it appears.
// ----------------------------------------------------------------------------
module point_set_centroid_shift_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]    paddr,
  input  logic [psc_pkg::DATA_W-1:0]    pwdata,
  output logic [psc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // Point input
  input  logic                          start,
  output logic                          busy,
  input  logic signed [psc_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [psc_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [psc_pkg::COORD_W-1:0] point_z_i,
  input  logic                          set_end_i,
  // Result output
  output logic                          valid_o,
  output logic signed [psc_pkg::COORD_W-1:0] out_x_o,
  output logic signed [psc_pkg::COORD_W-1:0] out_y_o,
  output logic signed [psc_pkg::COORD_W-1:0] out_z_o,
  output logic                          run_last_o,
  output logic                          points_dropped_o
);
  import psc_pkg::*;

  cfg_t   cfg;
  state_e state_q, state_d;

  // Set accumulation
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d, sum_z_q, sum_z_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  // Flush bookkeeping
  logic [CNT_W-1:0]   n_q, n_d;
  logic               drop_q, drop_d;
  logic [COORD_W-1:0] cen_x_q, cen_x_d, cen_y_q, cen_y_d, cen_z_q, cen_z_d;
  logic [WIDE_W-1:0]  off_x_q, off_x_d, off_y_q, off_y_d, off_z_q, off_z_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;

  // Output register
  logic               vld_q, vld_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic               last_q, last_d;
  logic               odrop_q, odrop_d;

  logic               accept, acc_cen, acc_add, store_ok;
  logic               div_start;
  logic               dx_done, dy_done, dz_done;
  logic [SUM_W-1:0]   qx, qy, qz;
  logic [PT_W-1:0]    rdata;
  logic [WIDE_W-1:0]  ax, ay, az, bx, by, bz;
  logic               rd_is_last;

  psc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign acc_cen  = accept && cfg.centering_mode;
  assign acc_add  = accept && !cfg.centering_mode;
  assign store_ok = (cnt_q < CNT_W'(MAX_POINTS));

  // Point buffer: writes happen only while loading and read data is used only
  // while flushing, so a used read never meets a write in the same cycle
  psc_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc_cen && store_ok),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({point_z_i, point_y_i, point_x_i}),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // One divider per axis, all started together
  psc_div u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_x_q), .divisor_i (cnt_q), .done_o (dx_done), .quotient_o (qx)
  );
  psc_div u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_y_q), .divisor_i (cnt_q), .done_o (dy_done), .quotient_o (qy)
  );
  psc_div u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_z_q), .divisor_i (cnt_q), .done_o (dz_done), .quotient_o (qz)
  );

  assign rd_is_last = (rd_cnt_q == (n_q - 1'b1));

  // Sequencer and accumulators
  always_comb begin
    state_d   = state_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    sum_z_d   = sum_z_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    drop_d    = drop_q;
    cen_x_d   = cen_x_q;
    cen_y_d   = cen_y_q;
    cen_z_d   = cen_z_q;
    off_x_d   = off_x_q;
    off_y_d   = off_y_q;
    off_z_d   = off_z_q;
    rd_cnt_d  = rd_cnt_q;
    rd_pend_d = 1'b0;
    rd_last_d = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (acc_cen) begin
          // Store and sum while there is room, else mark the set lossy
          if (store_ok) begin
            sum_x_d = sum_x_q + {{(SUM_W-COORD_W){point_x_i[COORD_W-1]}}, point_x_i};
            sum_y_d = sum_y_q + {{(SUM_W-COORD_W){point_y_i[COORD_W-1]}}, point_y_i};
            sum_z_d = sum_z_q + {{(SUM_W-COORD_W){point_z_i[COORD_W-1]}}, point_z_i};
            cnt_d   = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (set_end_i) begin
            state_d = ST_DSTART;
          end
        end
      end
      ST_DSTART: begin
        // Launch the dividers, latch the set summary, free the accumulators
        div_start = 1'b1;
        n_d       = cnt_q;
        drop_d    = ovf_q;
        sum_x_d   = '0;
        sum_y_d   = '0;
        sum_z_d   = '0;
        cnt_d     = '0;
        ovf_d     = 1'b0;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (dx_done && dy_done && dz_done) begin
          cen_x_d = qx[COORD_W-1:0];
          cen_y_d = qy[COORD_W-1:0];
          cen_z_d = qz[COORD_W-1:0];
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Fold centroid and shift into one offset per axis
        off_x_d  = ext_wide(cfg.shift_x) - ext_wide(cen_x_q);
        off_y_d  = ext_wide(cfg.shift_y) - ext_wide(cen_y_q);
        off_z_d  = ext_wide(cfg.shift_z) - ext_wide(cen_z_q);
        rd_cnt_d = '0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // Issue one buffer read per cycle
        rd_pend_d = 1'b1;
        rd_last_d = rd_is_last;
        rd_cnt_d  = rd_cnt_q + 1'b1;
        if (rd_is_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result datapath: buffered point plus offset, or live point plus shift
  always_comb begin
    if (rd_pend_q) begin
      ax = ext_wide(rdata[COORD_W-1:0]);
      ay = ext_wide(rdata[2*COORD_W-1:COORD_W]);
      az = ext_wide(rdata[3*COORD_W-1:2*COORD_W]);
      bx = off_x_q;
      by = off_y_q;
      bz = off_z_q;
    end else begin
      ax = ext_wide(point_x_i);
      ay = ext_wide(point_y_i);
      az = ext_wide(point_z_i);
      bx = ext_wide(cfg.shift_x);
      by = ext_wide(cfg.shift_y);
      bz = ext_wide(cfg.shift_z);
    end
    vld_d   = rd_pend_q || acc_add;
    ox_d    = sat_coord(ax + bx);
    oy_d    = sat_coord(ay + by);
    oz_d    = sat_coord(az + bz);
    last_d  = rd_pend_q ? rd_last_q : set_end_i;
    odrop_d = rd_pend_q && drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sum_z_q   <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      n_q       <= '0;
      drop_q    <= 1'b0;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      sum_z_q   <= sum_z_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      n_q       <= n_d;
      drop_q    <= drop_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_pend_q <= rd_pend_d;
      rd_last_q <= rd_last_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cen_x_q <= cen_x_d;
    cen_y_q <= cen_y_d;
    cen_z_q <= cen_z_d;
    off_x_q <= off_x_d;
    off_y_q <= off_y_d;
    off_z_q <= off_z_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oz_q    <= oz_d;
    last_q  <= last_d;
    odrop_q <= odrop_d;
  end

  assign valid_o          = vld_q;
  assign out_x_o          = ox_q;
  assign out_y_o          = oy_q;
  assign out_z_o          = oz_q;
  assign run_last_o       = vld_q && last_q;
  assign points_dropped_o = vld_q && odrop_q;

endmodule

@@ rtl/psc_checker.sv @@
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the point set centroid shift core, bound to the top.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic run_last_o,
  input logic points_dropped_o
);

  // Busy only ever starts from an accepted point
  a_busy_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted beat");

  // A flush ends with its last point shown as busy drops
  a_flush_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (valid_o && run_last_o))
    else $error("busy fell without the last beat of the set");

  // Set flags only travel with a result beat
  a_last_in_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_last_o |-> valid_o)
    else $error("run_last_o outside a result beat");

  a_drop_in_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    points_dropped_o |-> (valid_o && busy) || (valid_o && run_last_o))
    else $error("points_dropped_o outside a flushed set");

endmodule

bind point_set_centroid_shift_core psc_checker u_psc_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point set centroid shift core. Points are fed on
// the start/busy handshake while a scoreboard predicts every shifted point,
// either at once (additive mode) or as a whole set flushed on set_end
// (centering mode). Registers are written over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import psc_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 11;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 84;

  localparam logic [COORD_W-1:0] C_MAX  = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COORD_W-1:0] C_ZERO = 32'h0000_0000;
  localparam logic [COORD_W-1:0] C_NEG1 = 32'hffff_ffff;
  localparam logic [COORD_W-1:0] C_ONE  = 32'h0001_0000;

  // One shifted point as it should leave the block
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
    logic               dropped;
  } shifted_pt_t;

  // --------------------------------------------------------------------------
  // Scoreboard: centroid predictor plus queue of shifted points in flight
  // --------------------------------------------------------------------------
  class centroid_board;
    logic               centering = 1'b1;
    logic [COORD_W-1:0] sh_x = '0;
    logic [COORD_W-1:0] sh_y = '0;
    logic [COORD_W-1:0] sh_z = '0;

    logic [COORD_W-1:0] held_x[MAX_POINTS];
    logic [COORD_W-1:0] held_y[MAX_POINTS];
    logic [COORD_W-1:0] held_z[MAX_POINTS];
    longint             acc_x = 0;
    longint             acc_y = 0;
    longint             acc_z = 0;
    int                 held = 0;
    logic               lost = 1'b0;

    shifted_pt_t        pending_pts[$];
    int                 errors = 0;
    int                 n_results = 0;
    int                 n_flushes = 0;
    int                 n_lossy = 0;

    function longint wide(logic [COORD_W-1:0] v);
      return longint'($signed(v));
    endfunction

    function logic [COORD_W-1:0] clamp(longint v);
      if (v > longint'(2147483647)) return C_MAX;
      if (v < -longint'(2147483647) - 1) return C_MIN;
      return v[COORD_W-1:0];
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_MODE:    centering = v[0];
        REG_SHIFT_X: sh_x = v;
        REG_SHIFT_Y: sh_y = v;
        REG_SHIFT_Z: sh_z = v;
        default: ;
      endcase
    endfunction

    // Predict the results of one accepted point
    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic last);
      shifted_pt_t r;
      longint      cx, cy, cz;
      if (!centering) begin
        r.x = clamp(wide(x) + wide(sh_x));
        r.y = clamp(wide(y) + wide(sh_y));
        r.z = clamp(wide(z) + wide(sh_z));
        r.last = last;
        r.dropped = 1'b0;
        pending_pts.push_back(r);
        return;
      end
      // Buffer and sum while there is room, else flag the set
      if (held < MAX_POINTS) begin
        held_x[held] = x;
        held_y[held] = y;
        held_z[held] = z;
        acc_x += wide(x);
        acc_y += wide(y);
        acc_z += wide(z);
        held++;
      end else begin
        lost = 1'b1;
      end
      if (!last) return;
      // Flush: centroid truncates toward zero
      if (held > 0) begin
        cx = acc_x / longint'(held);
        cy = acc_y / longint'(held);
        cz = acc_z / longint'(held);
        for (int k = 0; k < held; k++) begin
          r.x = clamp(wide(held_x[k]) - cx + wide(sh_x));
          r.y = clamp(wide(held_y[k]) - cy + wide(sh_y));
          r.z = clamp(wide(held_z[k]) - cz + wide(sh_z));
          r.last = (k == held - 1);
          r.dropped = lost;
          pending_pts.push_back(r);
        end
      end
      n_flushes++;
      if (lost) n_lossy++;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      held = 0;
      lost = 1'b0;
    endfunction

    function void cmp_field(string name, logic [COORD_W-1:0] e, logic [COORD_W-1:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z, logic last, logic dropped);
      shifted_pt_t e;
      n_results++;
      if (pending_pts.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, got %h %h %h %b %b",
                 $time, x, y, z, last, dropped);
        errors++;
        return;
      end
      e = pending_pts.pop_front();
      cmp_field("out_x", e.x, x);
      cmp_field("out_y", e.y, y);
      cmp_field("out_z", e.z, z);
      cmp_field("run_last", {31'b0, e.last}, {31'b0, last});
      cmp_field("points_dropped", {31'b0, e.dropped}, {31'b0, dropped});
    endfunction

    function int outstanding();
      return pending_pts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  logic [COORD_W-1:0]  point_x = '0;
  logic [COORD_W-1:0]  point_y = '0;
  logic [COORD_W-1:0]  point_z = '0;
  logic                set_end = 1'b0;
  logic                valid_o;
  logic [COORD_W-1:0]  out_x, out_y, out_z;
  logic                run_last, points_dropped;

  centroid_board board = new();
  int                  n_points = 0;
  int                  n_writes = 0;
  int                  cycles = 0;
  bit                  no_idle = 1'b0;

  point_set_centroid_shift_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .point_x_i        (point_x),
    .point_y_i        (point_y),
    .point_z_i        (point_z),
    .set_end_i        (set_end),
    .valid_o          (valid_o),
    .out_x_o          (out_x),
    .out_y_o          (out_y),
    .out_z_o          (out_z),
    .run_last_o       (run_last),
    .points_dropped_o (points_dropped)
  );

  // Clock
  always #CLK_HALF clk_i = ~clk_i;

  // Capture every result beat; the strobe cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      board.check_point(out_x, out_y, out_z, run_last, points_dropped);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycles, board.outstanding());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mix of full-range, small and corner coordinates
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return 32'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
    case ($urandom_range(0, 3))
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ZERO;
      default: return C_NEG1;
    endcase
  endfunction

  // Send one point beat and hold it until accepted
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    set_end <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_point(x, y, z, last);
    n_points++;
  endtask

  // Drop start and wait until every predicted beat is out and the core idles
  task automatic settle();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready, then idle with psel low
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, v);
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic write_shifts(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [COORD_W-1:0] sz);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
  endtask

  // Mode bit with junk above it, which the core must mask
  task automatic write_mode(input logic mode);
    write_reg(REG_MODE, {31'($urandom), mode});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_items;
    int set_no;
    int set_len;
    bit big;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: centering, zero shift. Single-point set, extreme pair,
    // and a negative sum that truncates toward zero.
    send_point(C_MAX, C_MIN, C_ZERO, 1'b1);
    send_point(C_MAX, C_MIN, C_NEG1, 1'b0);
    send_point(C_MIN, C_MAX, C_ZERO, 1'b1);
    send_point(32'hffff_fffd, 32'hffff_fffe, 32'h0000_0005, 1'b0);
    send_point(32'hffff_fffe, 32'hffff_fffe, 32'h0000_0001, 1'b0);
    send_point(32'hffff_fffe, 32'hffff_fffd, 32'h0000_0002, 1'b1);
    settle();

    // Additive mode with saturating shifts
    write_mode(1'b0);
    write_shifts(C_MAX, C_MIN, C_ONE);
    send_point(C_MAX, C_MIN, C_ZERO, 1'b0);
    send_point(C_MIN, C_MAX, C_NEG1, 1'b1);
    send_point(C_ZERO, C_ZERO, C_MAX, 1'b0);
    send_point(C_ONE, C_NEG1, C_MIN, 1'b1);
    settle();

    // Centering with saturating shifts; a half-buffered set survives a
    // detour through additive mode and is flushed afterwards
    write_mode(1'b1);
    write_shifts(C_MIN, C_MAX, C_NEG1);
    send_point(C_MAX, C_MIN, C_ONE, 1'b0);
    send_point(C_MIN, C_MAX, C_ZERO, 1'b1);
    send_point(C_MAX, C_MAX, C_MIN, 1'b0);
    send_point(C_ONE, C_NEG1, C_MAX, 1'b0);
    settle();
    write_mode(1'b0);
    send_point(C_NEG1, C_ONE, C_ZERO, 1'b0);
    send_point(C_MAX, C_ZERO, C_MIN, 1'b1);
    settle();
    write_mode(1'b1);
    send_point(C_ZERO, C_MIN, C_ONE, 1'b1);
    settle();

    // Random sets; one large set fills the buffer and overflows it
    rand_items = 0;
    set_no = 0;
    while (rand_items < RAND_ITEMS) begin
      big = (set_no == 2);
      if (set_no % 4 == 0 || big) begin
        settle();
        write_mode(big ? 1'b1 : ($urandom_range(0, 9) < 7));
        write_shifts(pick_coord(), pick_coord(), pick_coord());
      end
      no_idle = (set_no % 3 == 1);
      if (big) set_len = MAX_POINTS + 2;
      else set_len = $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        send_point(pick_coord(), pick_coord(), pick_coord(), k == set_len - 1);
        rand_items++;
      end
      set_no++;
    end
    settle();

    $display("Covered %0d points in %0d flushed sets (%0d with overflow), %0d register writes.",
             n_points, board.n_flushes, board.n_lossy, n_writes);
    $display("Checked %0d result beats with %0d mismatches.", board.n_results, board.errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/psc_pkg.sv
rtl/psc_ram.sv
rtl/psc_div.sv
rtl/psc_regs.sv
rtl/point_set_centroid_shift_core.sv
rtl/psc_checker.sv
tb/tb_top.sv
